// ----- rtl/sarp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the SMBus address-resolution allocator: beat types, operation,
// status and register codes, and the reserved-address check. No dependencies.
package sarp_pkg;

  localparam int MAX_DEVICES = 8;
  localparam int TBL_IDX_W   = $clog2(MAX_DEVICES);
  localparam int PLAT_REGS   = 4;

  localparam logic [6:0] ADDR_UNASSIGNED = 7'h7F;
  localparam logic [6:0] SEARCH_FIRST    = 7'h03;
  localparam logic [6:0] SEARCH_LAST     = 7'h7E;
  localparam logic [7:0] CAP_NOT_FIXED   = 8'hC0;

  localparam int SPEC_RSVD_COUNT = 21;
  localparam logic [7:0] SPEC_RSVD [SPEC_RSVD_COUNT] = '{
    8'h00, 8'h02, 8'h04, 8'h06, 8'h08, 8'h0A, 8'h0C, 8'h0E, 8'h10, 8'h18, 8'h50,
    8'h6E, 8'hC2, 8'hF0, 8'hF2, 8'hF4, 8'hF6, 8'hF8, 8'hFA, 8'hFC, 8'hFE
  };

  typedef enum logic [2:0] {
    OP_PROPOSE_DISC  = 3'd0,
    OP_PROPOSE_DIRECT = 3'd1,
    OP_COMMIT        = 3'd2,
    OP_CLEAR         = 3'd3,
    OP_READ_ENTRY    = 3'd4
  } sarp_op_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_RES    = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

  localparam logic [2:0] REG_PLAT_COUNT = 3'd0;
  localparam logic [2:0] REG_PLAT_A     = 3'd1;
  localparam logic [2:0] REG_PLAT_B     = 3'd2;
  localparam logic [2:0] REG_PLAT_C     = 3'd3;
  localparam logic [2:0] REG_PLAT_D     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHECK,
    ST_SEARCH
  } sarp_state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] device_address;
    logic [7:0] capabilities;
    logic [2:0] entry_index;
  } sarp_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] chosen_address;
    logic [3:0] entry_count;
  } sarp_out_t;

  // True when the shifted 8-bit form of the address is on the SMBus reserved list.
  function automatic logic spec_reserved(input logic [6:0] addr);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SPEC_RSVD_COUNT; i++) begin
      if (SPEC_RSVD[i] == {addr, 1'b0}) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ----- rtl/smbus_arp_address_allocator.sv -----
`timescale 1ns / 1ps
// Top level of the SMBus address-resolution allocator: sequencer, address table
// and the shared free-address check. Depends on sarp_pkg.

// An item is taken when start is high and busy is low. Busy then stays high
// until the cycle in which the single result beat appears on out_data with
// out_valid high; busy is already low in that cycle, so the next item may be
// taken at the same edge that takes the result. The receiver cannot stall, so
// it must take every beat as it comes. Commit, clear, read-entry and unknown
// operations, proposals on a full table and a discovered device keeping its own
// address all register their result straight from the evaluation state. A
// proposal that must look for a free address walks the candidates 0x03 to 0x7E
// one per cycle through a single free-address checker (after the check state
// when the reported address is checked first); that walk sets the rate.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
module smbus_arp_address_allocator
  import sarp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sarp_in_t  in_data,
  output logic      out_valid,
  output sarp_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  sarp_state_t state_r, state_nxt;
  sarp_in_t    item_r;
  logic [6:0]  cand_r, cand_nxt;
  logic [3:0]  count_r, count_nxt;
  logic        out_valid_r, out_valid_nxt;
  sarp_out_t   out_data_r, out_data_nxt;
  logic        tbl_we;

  logic [2:0]  plat_count_r;
  logic [7:0]  plat_r [PLAT_REGS];
  logic [6:0]  addr_tbl_r [MAX_DEVICES];

  logic [2:0]  nplat;
  logic        cand_free;
  logic        full;
  logic        accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = (count_r >= 4'(MAX_DEVICES));
  assign nplat     = (plat_count_r > 3'(PLAT_REGS)) ? 3'(PLAT_REGS) : plat_count_r;

  // Shared free-address checker: one candidate per cycle against the table,
  // the platform registers in use and the spec reserved list.
  always_comb begin
    cand_free = !spec_reserved(cand_r);
    for (int i = 0; i < MAX_DEVICES; i++) begin
      if ((4'(i) < count_r) && (addr_tbl_r[i] == cand_r)) begin
        cand_free = 1'b0;
      end
    end
    for (int j = 0; j < PLAT_REGS; j++) begin
      if ((3'(j) < nplat) && (plat_r[j] == {cand_r, 1'b0})) begin
        cand_free = 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
        if (!full) begin
          if (item_r.operation == OP_PROPOSE_DIRECT) begin
            state_nxt = ST_SEARCH;
          end else if (item_r.operation == OP_PROPOSE_DISC) begin
            if (item_r.device_address == ADDR_UNASSIGNED) begin
              state_nxt = ST_SEARCH;
            end else if ((item_r.capabilities & CAP_NOT_FIXED) != 8'd0) begin
              state_nxt = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        state_nxt = cand_free ? ST_IDLE : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cand_free || (cand_r == SEARCH_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result beat.
  always_comb begin
    cand_nxt      = cand_r;
    count_nxt     = count_r;
    tbl_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        cand_nxt = SEARCH_FIRST;
      end
      ST_EVAL: begin
        out_data_nxt.status         = STAT_OK;
        out_data_nxt.chosen_address = 7'd0;
        case (item_r.operation)
          OP_PROPOSE_DISC: begin
            if (full) begin
              out_data_nxt.status = STAT_NO_RES;
              out_valid_nxt       = 1'b1;
            end else if (item_r.device_address == ADDR_UNASSIGNED) begin
              cand_nxt = SEARCH_FIRST;
            end else if ((item_r.capabilities & CAP_NOT_FIXED) != 8'd0) begin
              cand_nxt = item_r.device_address;
            end else begin
              out_data_nxt.chosen_address = item_r.device_address;
              out_valid_nxt               = 1'b1;
            end
          end
          OP_PROPOSE_DIRECT: begin
            if (full) begin
              out_data_nxt.status = STAT_NO_RES;
              out_valid_nxt       = 1'b1;
            end else begin
              cand_nxt = SEARCH_FIRST;
            end
          end
          OP_COMMIT: begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_data_nxt.status = STAT_NO_RES;
            end else begin
              tbl_we                      = 1'b1;
              count_nxt                   = count_r + 4'd1;
              out_data_nxt.chosen_address = item_r.device_address;
            end
          end
          OP_CLEAR: begin
            count_nxt     = 4'd0;
            out_valid_nxt = 1'b1;
          end
          OP_READ_ENTRY: begin
            out_valid_nxt = 1'b1;
            if ({1'b0, item_r.entry_index} < count_r) begin
              out_data_nxt.chosen_address = addr_tbl_r[item_r.entry_index[TBL_IDX_W-1:0]];
            end else begin
              out_data_nxt.status = STAT_BAD_INDEX;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
        out_data_nxt.entry_count = count_nxt;
      end
      ST_CHECK: begin
        if (cand_free) begin
          out_data_nxt.chosen_address = cand_r;
          out_valid_nxt               = 1'b1;
        end else begin
          cand_nxt = SEARCH_FIRST;
        end
      end
      ST_SEARCH: begin
        if (cand_free) begin
          out_data_nxt.chosen_address = cand_r;
          out_valid_nxt               = 1'b1;
        end else if (cand_r == SEARCH_LAST) begin
          out_data_nxt.status         = STAT_NO_RES;
          out_data_nxt.chosen_address = 7'd0;
          out_valid_nxt               = 1'b1;
        end else begin
          cand_nxt = cand_r + 7'd1;
        end
      end
      default: begin
        cand_nxt = SEARCH_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      item_r <= in_data;
    end
    if (tbl_we) begin
      addr_tbl_r[count_r[TBL_IDX_W-1:0]] <= item_r.device_address;
    end
  end

  // Platform reserved registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plat_count_r <= 3'd0;
      for (int k = 0; k < PLAT_REGS; k++) begin
        plat_r[k] <= 8'd0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PLAT_COUNT: plat_count_r <= cfg_data[2:0];
        REG_PLAT_A:     plat_r[0]    <= cfg_data;
        REG_PLAT_B:     plat_r[1]    <= cfg_data;
        REG_PLAT_C:     plat_r[2]    <= cfg_data;
        REG_PLAT_D:     plat_r[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A result beat only appears once the sequencer has returned to idle.
  a_beat_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result beat while sequencer busy");

  // An accepted item always makes the block busy on the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  // The table count never exceeds its capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 4'(MAX_DEVICES))
    else $error("table count beyond capacity");

  // The search walk stays within the legal candidate window.
  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> ((cand_r >= SEARCH_FIRST) && (cand_r <= SEARCH_LAST)))
    else $error("search candidate out of range");

  // A successful search result is a candidate the checker found free.
  a_search_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SEARCH) && cand_free) |=>
      (out_valid_r && (out_data_r.status == STAT_OK)))
    else $error("free candidate not reported");

endmodule
